// ===== src/two_pkg.sv =====
// Package for the tracking wheel odometry block: states, register indexes, constants.
package two_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_FOLD,
        ST_RAD,
        ST_RDIV,
        ST_SQ,
        ST_TDIV,
        ST_TMUL,
        ST_SINM,
        ST_TRIG,
        ST_DMUL,
        ST_RMUL,
        ST_SAT,
        ST_DONE
    } state_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SCALE = 2'd2;

    localparam logic [39:0] START_X_RESET = 40'd832768;
    localparam logic [39:0] START_Y_RESET = 40'd234240;
    localparam logic [31:0] SCALE_RESET   = 32'd26180241;

    // pi in Q32
    localparam logic [33:0] PI_Q32 = 34'd13493037705;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // heading reduction: u = h + 2^31, and 2^31 mod 36000 = 11648
    localparam logic [15:0] FULL_TURN   = 16'd36000;
    localparam logic [15:0] HEAD_OFFSET = 16'd11648;
    localparam logic [15:0] TURN_REST   = 16'd24352;
    localparam logic [15:0] QUARTER     = 16'd9000;
    localparam logic [15:0] HALF_TURN   = 16'd18000;
    localparam logic [15:0] THREE_QTR   = 16'd27000;
    localparam logic [15:0] OCTANT      = 16'd4500;
    localparam logic [15:0] RAD_DIV     = 16'd18000;
    localparam logic [47:0] RAD_ROUND   = 48'd9000;

    // serial unit lengths
    localparam int DIV_W = 48;
    localparam int MUL_B = 33;
    localparam int CNT_W = 6;

    // series term indexes: sine terms first, then cosine terms
    localparam logic [3:0] TERM_SIN_FIRST = 4'd0;
    localparam logic [3:0] TERM_SIN_LAST  = 4'd4;
    localparam logic [3:0] TERM_COS_FIRST = 4'd5;
    localparam logic [3:0] TERM_COS_LAST  = 4'd10;

    // divisor of r^2 for each series term
    function automatic logic [15:0] series_div(input logic [3:0] idx);
        logic [15:0] d;
        unique case (idx)
            4'd0:    d = 16'd110;
            4'd1:    d = 16'd72;
            4'd2:    d = 16'd42;
            4'd3:    d = 16'd20;
            4'd4:    d = 16'd6;
            4'd5:    d = 16'd132;
            4'd6:    d = 16'd90;
            4'd7:    d = 16'd56;
            4'd8:    d = 16'd30;
            4'd9:    d = 16'd12;
            default: d = 16'd2;
        endcase
        return d;
    endfunction

endpackage

// ===== src/tracking_wheel_odometry.sv =====
// Top level of the tracking wheel odometry block: bit-serial sequencer and datapath.
//
//  channel | direction | handshake              | words
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall    | forward_count, side_count, gyro_heading
//  out     | out       | out_valid / out_stall  | x_out, y_out, heading_out
//
// The first word after reset goes straight to the output with the start position; every
// later word takes 18 products from one shared bit-serial multiplier and 13 quotients
// from one bit-serial constant divider.
// Reset clears the state; start_x and start_y load at the first word after reset.
// in_stall is high while a word is at work; a result waiting in the output register
// does not block the next word until that word is finished.
module tracking_wheel_odometry #(
    parameter int TRIG_FRACTION_BITS     = 16,
    parameter int POSITION_FRACTION_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [two_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [39:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             forward_count,
    input  logic signed [31:0]             side_count,
    input  logic signed [31:0]             gyro_heading,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [39:0]             x_out,
    output logic signed [39:0]             y_out,
    output logic signed [31:0]             heading_out
);
    import two_pkg::*;

    localparam int T   = TRIG_FRACTION_BITS;
    localparam int P   = POSITION_FRACTION_BITS;
    localparam int DW  = 32 + P;
    localparam int KU  = T + 1;
    localparam int KW  = T + 2;
    localparam int AW  = (DW + T + 3 > 68) ? DW + T + 3 : 68;
    localparam int SW  = ((DW > 40) ? DW : 40) + 3;
    localparam int DSH = 32 - P;

    localparam logic signed [SW-1:0] POS_MAX = SW'(40'sh7F_FFFF_FFFF);
    localparam logic signed [SW-1:0] POS_MIN = SW'(-(SW'(40'sh7F_FFFF_FFFF)) - 1);

    // state and datapath registers
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [3:0]             idx_reg, idx_next;
    logic signed [AW-1:0]   mcand_reg, mcand_next;
    logic [MUL_B-1:0]       mpl_reg, mpl_next;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic [DIV_W-1:0]       dvd_reg, dvd_next;
    logic [15:0]            rem_reg, rem_next;
    logic [15:0]            dsr_reg, dsr_next;
    logic [39:0]            start_x_reg, start_x_next;
    logic [39:0]            start_y_reg, start_y_next;
    logic [31:0]            scale_reg, scale_next;
    logic [31:0]            last_fwd_reg, last_fwd_next;
    logic [31:0]            last_side_reg, last_side_next;
    logic [31:0]            held_reg, held_next;
    logic [31:0]            head_new_reg, head_new_next;
    logic                   primed_reg, primed_next;
    logic signed [31:0]     dfw_reg, dfw_next;
    logic signed [31:0]     dsw_reg, dsw_next;
    logic [1:0]             quad_reg, quad_next;
    logic                   swap_reg, swap_next;
    logic [31:0]            r_reg, r_next;
    logic [31:0]            r2_reg, r2_next;
    logic [32:0]            t_reg, t_next;
    logic [32:0]            sin_raw_reg, sin_raw_next;
    logic signed [KW-1:0]   s_reg, s_next;
    logic signed [KW-1:0]   c_reg, c_next;
    logic signed [DW-1:0]   df_reg, df_next;
    logic signed [DW-1:0]   ds_reg, ds_next;
    logic signed [SW-1:0]   ax_reg, ax_next;
    logic signed [SW-1:0]   ay_reg, ay_next;
    logic signed [39:0]     pos_x_reg, pos_x_next;
    logic signed [39:0]     pos_y_reg, pos_y_next;
    logic signed [39:0]     x_out_reg, x_out_next;
    logic signed [39:0]     y_out_reg, y_out_next;
    logic signed [31:0]     head_out_reg, head_out_next;
    logic                   out_valid_reg, out_valid_next;

    // serial unit step values
    logic signed [AW-1:0]   acc_step;
    logic [MUL_B-1:0]       mpl_step;
    logic [16:0]            rem2;
    logic                   div_ge;
    logic [15:0]            rem_step;
    logic [DIV_W-1:0]       dvd_step;
    logic                   mul_last;
    logic                   div_last;

    // fold and trig values
    logic [15:0]            fold_a;
    logic [1:0]             fold_q;
    logic [15:0]            fold_b;
    logic                   fold_swap;
    logic [15:0]            fold_bf;
    logic [KU-1:0]          sin_q;
    logic [KU-1:0]          cos_q;
    logic signed [KW-1:0]   s0;
    logic signed [KW-1:0]   c0;
    logic signed [DW-1:0]   dist_mm;
    logic                   in_take;
    logic                   out_free;

    // rotation term values
    logic signed [KW-1:0]   rot_k;
    logic signed [AW-1:0]   rot_prod;
    logic signed [SW-1:0]   rot_term;
    logic signed [KW-1:0]   next_k;
    logic signed [KW-1:0]   next_kabs;
    logic signed [DW-1:0]   next_d;

    function automatic logic [KU-1:0] to_trig(input logic [32:0] v);
        logic [33:0] sum;
        sum = {1'b0, v} + (34'd1 << (31 - T));
        return KU'(sum >> (32 - T));
    endfunction

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign x_out       = x_out_reg;
    assign y_out       = y_out_reg;
    assign heading_out = head_out_reg;

    // shift-add multiplier step, multiplier MSB first
    assign acc_step = (acc_reg <<< 1) + (mpl_reg[MUL_B-1] ? mcand_reg : '0);
    assign mpl_step = mpl_reg << 1;
    assign mul_last = (cnt_reg == CNT_W'(MUL_B - 1));

    // restoring divider step by a constant divisor
    assign rem2     = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_ge   = (rem2 >= {1'b0, dsr_reg});
    assign rem_step = div_ge ? 16'(rem2 - {1'b0, dsr_reg}) : rem2[15:0];
    assign dvd_step = {dvd_reg[DIV_W-2:0], div_ge};
    assign div_last = (cnt_reg == CNT_W'(DIV_W - 1));

    // heading to quadrant and folded octant angle
    always_comb
    begin
        fold_a = (rem_reg >= HEAD_OFFSET) ? rem_reg - HEAD_OFFSET : rem_reg + TURN_REST;
        priority if (fold_a >= THREE_QTR)
        begin
            fold_q = 2'd3;
            fold_b = fold_a - THREE_QTR;
        end
        else if (fold_a >= HALF_TURN)
        begin
            fold_q = 2'd2;
            fold_b = fold_a - HALF_TURN;
        end
        else if (fold_a >= QUARTER)
        begin
            fold_q = 2'd1;
            fold_b = fold_a - QUARTER;
        end
        else
        begin
            fold_q = 2'd0;
            fold_b = fold_a;
        end
        fold_swap = (fold_b > OCTANT);
        fold_bf   = fold_swap ? QUARTER - fold_b : fold_b;
    end

    // octant results to signed sine and cosine
    always_comb
    begin
        sin_q = to_trig(swap_reg ? t_reg : sin_raw_reg);
        cos_q = to_trig(swap_reg ? sin_raw_reg : t_reg);
        s0    = $signed({1'b0, sin_q});
        c0    = $signed({1'b0, cos_q});
    end

    // distance and rotation term from the finished product
    always_comb
    begin
        dist_mm  = DW'(acc_step >>> DSH);
        rot_k    = (idx_reg == 4'd0 || idx_reg == 4'd2) ? c_reg : s_reg;
        rot_prod = rot_k[KW-1] ? -acc_step : acc_step;
        rot_term = SW'(rot_prod >>> T);
        next_k    = (idx_reg == 4'd0 || idx_reg == 4'd2) ? s_reg : c_reg;
        next_kabs = next_k[KW-1] ? -next_k : next_k;
        next_d    = (idx_reg == 4'd0 || idx_reg == 4'd1) ? df_reg : ds_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + CNT_W'(1);
        idx_next       = idx_reg;
        mcand_next     = mcand_reg;
        mpl_next       = mpl_reg;
        acc_next       = acc_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        scale_next     = scale_reg;
        last_fwd_next  = last_fwd_reg;
        last_side_next = last_side_reg;
        held_next      = held_reg;
        head_new_next  = head_new_reg;
        primed_next    = primed_reg;
        dfw_next       = dfw_reg;
        dsw_next       = dsw_reg;
        quad_next      = quad_reg;
        swap_next      = swap_reg;
        r_next         = r_reg;
        r2_next        = r2_reg;
        t_next         = t_reg;
        sin_raw_next   = sin_raw_reg;
        s_next         = s_reg;
        c_next         = c_reg;
        df_next        = df_reg;
        ds_next        = ds_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        x_out_next     = x_out_reg;
        y_out_next     = y_out_reg;
        head_out_next  = head_out_reg;
        out_valid_next = out_valid_reg && out_stall;

        // config writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_X:     start_x_next = cfg_data;
                REG_START_Y:     start_y_next = cfg_data;
                REG_WHEEL_SCALE: scale_next   = cfg_data[31:0];
                default:         ;
            endcase
        end

        // serial units advance in their states
        if (state_reg == ST_RAD || state_reg == ST_SQ || state_reg == ST_TMUL ||
            state_reg == ST_SINM || state_reg == ST_DMUL || state_reg == ST_RMUL)
        begin
            acc_next = acc_step;
            mpl_next = mpl_step;
        end
        if (state_reg == ST_MOD || state_reg == ST_RDIV || state_reg == ST_TDIV)
        begin
            rem_next = rem_step;
            dvd_next = dvd_step;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_take)
                begin
                    last_fwd_next  = forward_count;
                    last_side_next = side_count;
                    head_new_next  = gyro_heading;
                    dfw_next       = $signed(last_fwd_reg - forward_count);
                    dsw_next       = $signed(side_count - last_side_reg);
                    if (!primed_reg)
                    begin
                        primed_next = 1'b1;
                        pos_x_next  = $signed(start_x_reg);
                        pos_y_next  = $signed(start_y_reg);
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        dvd_next   = {16'd0, held_reg ^ 32'h8000_0000};
                        rem_next   = '0;
                        dsr_next   = FULL_TURN;
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (div_last)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                quad_next  = fold_q;
                swap_next  = fold_swap;
                mcand_next = AW'(PI_Q32);
                mpl_next   = MUL_B'(fold_bf);
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_RAD;
            end
            ST_RAD:
            begin
                if (mul_last)
                begin
                    dvd_next   = acc_step[DIV_W-1:0] + RAD_ROUND;
                    rem_next   = '0;
                    dsr_next   = RAD_DIV;
                    cnt_next   = '0;
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV:
            begin
                if (div_last)
                begin
                    r_next     = dvd_step[31:0];
                    mcand_next = AW'(dvd_step[31:0]);
                    mpl_next   = MUL_B'(dvd_step[31:0]);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (mul_last)
                begin
                    r2_next    = acc_step[63:32];
                    dvd_next   = {16'd0, acc_step[63:32]};
                    rem_next   = '0;
                    dsr_next   = series_div(TERM_SIN_FIRST);
                    idx_next   = TERM_SIN_FIRST;
                    cnt_next   = '0;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (div_last)
                begin
                    cnt_next = '0;
                    if (idx_reg == TERM_SIN_FIRST || idx_reg == TERM_COS_FIRST)
                    begin
                        // first term: t = 1 - r^2/d
                        t_next     = ONE_Q32 - {1'b0, dvd_step[31:0]};
                        idx_next   = idx_reg + 4'd1;
                        dvd_next   = {16'd0, r2_reg};
                        rem_next   = '0;
                        dsr_next   = series_div(idx_reg + 4'd1);
                        state_next = ST_TDIV;
                    end
                    else
                    begin
                        mcand_next = AW'(dvd_step[31:0]);
                        mpl_next   = t_reg;
                        acc_next   = '0;
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_TMUL:
            begin
                if (mul_last)
                begin
                    t_next   = ONE_Q32 - {1'b0, acc_step[63:32]};
                    cnt_next = '0;
                    priority if (idx_reg == TERM_SIN_LAST)
                    begin
                        mcand_next = AW'(r_reg);
                        mpl_next   = ONE_Q32 - {1'b0, acc_step[63:32]};
                        acc_next   = '0;
                        state_next = ST_SINM;
                    end
                    else if (idx_reg == TERM_COS_LAST)
                    begin
                        state_next = ST_TRIG;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        dvd_next   = {16'd0, r2_reg};
                        rem_next   = '0;
                        dsr_next   = series_div(idx_reg + 4'd1);
                        state_next = ST_TDIV;
                    end
                end
            end
            ST_SINM:
            begin
                if (mul_last)
                begin
                    sin_raw_next = {1'b0, acc_step[63:32]};
                    idx_next     = TERM_COS_FIRST;
                    dvd_next     = {16'd0, r2_reg};
                    rem_next     = '0;
                    dsr_next     = series_div(TERM_COS_FIRST);
                    cnt_next     = '0;
                    state_next   = ST_TDIV;
                end
            end
            ST_TRIG:
            begin
                unique case (quad_reg)
                    2'd0:
                    begin
                        s_next = s0;
                        c_next = c0;
                    end
                    2'd1:
                    begin
                        s_next = c0;
                        c_next = -s0;
                    end
                    2'd2:
                    begin
                        s_next = -s0;
                        c_next = -c0;
                    end
                    default:
                    begin
                        s_next = -c0;
                        c_next = s0;
                    end
                endcase
                mcand_next = AW'(dfw_reg);
                mpl_next   = MUL_B'(scale_reg);
                acc_next   = '0;
                cnt_next   = '0;
                idx_next   = 4'd0;
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                if (mul_last)
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (idx_reg == 4'd0)
                    begin
                        df_next    = dist_mm;
                        mcand_next = AW'(dsw_reg);
                        mpl_next   = MUL_B'(scale_reg);
                        idx_next   = 4'd1;
                    end
                    else
                    begin
                        // first rotation term: ds * cos
                        ds_next    = dist_mm;
                        ax_next    = SW'(pos_x_reg);
                        ay_next    = SW'(pos_y_reg);
                        mcand_next = AW'(dist_mm);
                        mpl_next   = MUL_B'($unsigned(c_reg[KW-1] ? -c_reg : c_reg));
                        idx_next   = 4'd0;
                        state_next = ST_RMUL;
                    end
                end
            end
            ST_RMUL:
            begin
                if (mul_last)
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    unique case (idx_reg[1:0])
                        2'd0:    ay_next = ay_reg - rot_term;
                        2'd1:    ay_next = ay_reg - rot_term;
                        2'd2:    ax_next = ax_reg + rot_term;
                        default: ax_next = ax_reg - rot_term;
                    endcase
                    if (idx_reg == 4'd3)
                    begin
                        state_next = ST_SAT;
                    end
                    else
                    begin
                        mcand_next = AW'(next_d);
                        mpl_next   = MUL_B'($unsigned(next_kabs));
                        idx_next   = idx_reg + 4'd1;
                    end
                end
            end
            ST_SAT:
            begin
                priority if (ax_reg > POS_MAX)
                    pos_x_next = 40'sh7F_FFFF_FFFF;
                else if (ax_reg < POS_MIN)
                    pos_x_next = -40'sh7F_FFFF_FFFF - 40'sd1;
                else
                    pos_x_next = 40'(ax_reg);
                priority if (ay_reg > POS_MAX)
                    pos_y_next = 40'sh7F_FFFF_FFFF;
                else if (ay_reg < POS_MIN)
                    pos_y_next = -40'sh7F_FFFF_FFFF - 40'sd1;
                else
                    pos_y_next = 40'(ay_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    x_out_next     = pos_x_reg;
                    y_out_next     = pos_y_reg;
                    head_out_next  = $signed(head_new_reg);
                    held_next      = head_new_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            start_x_reg   <= START_X_RESET;
            start_y_reg   <= START_Y_RESET;
            scale_reg     <= SCALE_RESET;
            last_fwd_reg  <= '0;
            last_side_reg <= '0;
            held_reg      <= '0;
            primed_reg    <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            start_x_reg   <= start_x_next;
            start_y_reg   <= start_y_next;
            scale_reg     <= scale_next;
            last_fwd_reg  <= last_fwd_next;
            last_side_reg <= last_side_next;
            held_reg      <= held_next;
            primed_reg    <= primed_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mcand_reg    <= mcand_next;
        mpl_reg      <= mpl_next;
        acc_reg      <= acc_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        head_new_reg <= head_new_next;
        dfw_reg      <= dfw_next;
        dsw_reg      <= dsw_next;
        quad_reg     <= quad_next;
        swap_reg     <= swap_next;
        r_reg        <= r_next;
        r2_reg       <= r2_next;
        t_reg        <= t_next;
        sin_raw_reg  <= sin_raw_next;
        s_reg        <= s_next;
        c_reg        <= c_next;
        df_reg       <= df_next;
        ds_reg       <= ds_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        x_out_reg    <= x_out_next;
        y_out_reg    <= y_out_next;
        head_out_reg <= head_out_next;
    end

`ifndef ASSERT_OFF
    // once primed, stays primed until reset
    a_primed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped");

    // a new result word only comes out of the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word loaded outside done state");

    // step counter never runs past the divider length while dividing
    a_cnt_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD || state_reg == ST_RDIV || state_reg == ST_TDIV)
            |-> cnt_reg <= CNT_W'(DIV_W - 1))
        else $error("divider counter out of range");

    // step counter never runs past the multiplier length while multiplying
    a_cnt_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RAD || state_reg == ST_SQ || state_reg == ST_TMUL ||
         state_reg == ST_SINM || state_reg == ST_DMUL || state_reg == ST_RMUL)
            |-> cnt_reg <= CNT_W'(MUL_B - 1))
        else $error("multiplier counter out of range");

    // divider never runs with a zero divisor
    a_dsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD || state_reg == ST_RDIV || state_reg == ST_TDIV)
            |-> dsr_reg != 16'd0)
        else $error("divider running with zero divisor");
`endif

endmodule
